// ----- design/wsat_pkg.sv -----
// shared types, register codes and reset constants for the work session alarm timer
package wsat_pkg;

  // counter width default
  localparam int unsigned CountWidth = 32;

  // configuration register width and index width
  localparam int unsigned CfgDataWidth = 32;
  localparam int unsigned CfgIdxWidth  = 3;

  // register reset values
  localparam logic [CfgDataWidth-1:0] RestTicksDef       = 32'd60000;
  localparam logic [CfgDataWidth-1:0] WorkTicksDef       = 32'd2400000;
  localparam logic [CfgDataWidth-1:0] AlarmQuietTicksDef = 32'd60000;
  localparam logic [CfgDataWidth-1:0] BreakGraceTicksDef = 32'd20000;
  localparam logic [CfgDataWidth-1:0] BlinkTicksDef      = 32'd500;

  // register indexes
  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_REST_TICKS  = 3'd0,
    CFG_WORK_TICKS  = 3'd1,
    CFG_QUIET_TICKS = 3'd2,
    CFG_GRACE_TICKS = 3'd3,
    CFG_BLINK_TICKS = 3'd4
  } cfg_idx_e;

  // phase codes
  typedef enum logic [2:0] {
    PH_REST  = 3'd0,
    PH_WORK  = 3'd1,
    PH_ALARM = 3'd2,
    PH_QUIET = 3'd3,
    PH_GRACE = 3'd4
  } phase_e;

  // limits handed to the controller
  typedef struct packed {
    logic [CfgDataWidth-1:0] rest_ticks;
    logic [CfgDataWidth-1:0] work_ticks;
    logic [CfgDataWidth-1:0] alarm_quiet_ticks;
    logic [CfgDataWidth-1:0] break_grace_ticks;
    logic [CfgDataWidth-1:0] blink_ticks;
  } wsat_cfg_t;

  // one result item
  typedef struct packed {
    logic [2:0] phase;
    logic       alarm_out;
    logic       rest_chirp;
  } wsat_result_t;

endpackage

// ----- design/wsat_if.sv -----
// request channel interfaces: tick input, result output and register writes

interface wsat_in_if;
  logic valid;
  logic ready;
  logic sensor_high;
  modport source (output valid, output sensor_high, input ready);
  modport sink (input valid, input sensor_high, output ready);
endinterface

interface wsat_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] phase;
  logic       alarm_out;
  logic       rest_chirp;
  modport source (output valid, output phase, output alarm_out, output rest_chirp,
                  input ready);
  modport sink (input valid, input phase, input alarm_out, input rest_chirp,
                output ready);
endinterface

interface wsat_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- design/wsat_cfg_regs.sv -----
// configuration register file for the timer limits
module wsat_cfg_regs
  import wsat_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    wr_en_i,
  input  logic [CfgIdxWidth-1:0]  wr_idx_i,
  input  logic [CfgDataWidth-1:0] wr_data_i,
  output wsat_cfg_t               cfg_o
);

  wsat_cfg_t cfg_q, cfg_d;

  // decode the write index, unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (cfg_idx_e'(wr_idx_i))
        CFG_REST_TICKS:  cfg_d.rest_ticks        = wr_data_i;
        CFG_WORK_TICKS:  cfg_d.work_ticks        = wr_data_i;
        CFG_QUIET_TICKS: cfg_d.alarm_quiet_ticks = wr_data_i;
        CFG_GRACE_TICKS: cfg_d.break_grace_ticks = wr_data_i;
        CFG_BLINK_TICKS: cfg_d.blink_ticks       = wr_data_i;
        default: ;
      endcase
    end
  end

  // register storage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rest_ticks        <= RestTicksDef;
      cfg_q.work_ticks        <= WorkTicksDef;
      cfg_q.alarm_quiet_ticks <= AlarmQuietTicksDef;
      cfg_q.break_grace_ticks <= BreakGraceTicksDef;
      cfg_q.blink_ticks       <= BlinkTicksDef;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- design/wsat_ctrl.sv -----
// phase state machine, saturating counters and blink machine, one tick per request
module wsat_ctrl
  import wsat_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = CountWidth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         tick_i,
  input  logic         absent_i,
  input  wsat_cfg_t    cfg_i,
  output wsat_result_t result_o
);

  localparam int unsigned CmpWidth = (COUNT_WIDTH > CfgDataWidth) ? COUNT_WIDTH : CfgDataWidth;

  phase_e                 phase_q, phase_d;
  logic                   started_q, started_d;
  logic [COUNT_WIDTH-1:0] elapsed_q, elapsed_d;
  logic                   rest_complete_q, rest_complete_d;
  logic                   alarm_level_q, alarm_level_d;
  logic                   blink_waiting_q, blink_waiting_d;
  logic [COUNT_WIDTH-1:0] blink_elapsed_q, blink_elapsed_d;
  logic                   chirp;

  logic [COUNT_WIDTH-1:0] elapsed_inc, blink_inc;
  logic [CmpWidth-1:0]    elapsed_ext, blink_ext;
  logic                   work_reached, quiet_reached, grace_reached, rest_reached;
  logic                   blink_reached;

  // saturating increments
  assign elapsed_inc = (&elapsed_q) ? elapsed_q : elapsed_q + 1'b1;
  assign blink_inc   = (&blink_elapsed_q) ? blink_elapsed_q : blink_elapsed_q + 1'b1;

  // limit compares on the incremented counts
  assign elapsed_ext   = CmpWidth'(elapsed_inc);
  assign blink_ext     = CmpWidth'(blink_inc);
  assign work_reached  = elapsed_ext >= CmpWidth'(cfg_i.work_ticks);
  assign quiet_reached = elapsed_ext >= CmpWidth'(cfg_i.alarm_quiet_ticks);
  assign grace_reached = elapsed_ext >= CmpWidth'(cfg_i.break_grace_ticks);
  assign rest_reached  = elapsed_ext >= CmpWidth'(cfg_i.rest_ticks);
  assign blink_reached = blink_ext >= CmpWidth'(cfg_i.blink_ticks);

  // next state and result for one tick
  always_comb begin
    phase_d         = phase_q;
    started_d       = started_q;
    elapsed_d       = elapsed_q;
    rest_complete_d = rest_complete_q;
    alarm_level_d   = alarm_level_q;
    blink_waiting_d = blink_waiting_q;
    blink_elapsed_d = blink_elapsed_q;
    chirp           = 1'b0;
    if (!started_q) begin
      // first tick only picks the phase
      started_d = 1'b1;
      phase_d   = absent_i ? PH_REST : PH_WORK;
      elapsed_d = '0;
    end else begin
      elapsed_d       = elapsed_inc;
      blink_elapsed_d = blink_inc;
      case (phase_q)
        PH_WORK: begin
          if (work_reached) begin
            phase_d   = PH_ALARM;
            elapsed_d = '0;
            // zero elapsed is still below a non-zero limit
            if (absent_i && (cfg_i.work_ticks != '0)) begin
              phase_d = PH_GRACE;
            end
          end else if (absent_i) begin
            phase_d   = PH_GRACE;
            elapsed_d = '0;
          end
        end
        PH_ALARM: begin
          if (!blink_waiting_q) begin
            alarm_level_d   = ~alarm_level_q;
            blink_elapsed_d = '0;
            blink_waiting_d = 1'b1;
          end else if (blink_reached) begin
            blink_waiting_d = 1'b0;
          end
          if (absent_i) begin
            phase_d       = PH_QUIET;
            elapsed_d     = '0;
            alarm_level_d = 1'b0;
          end
        end
        PH_QUIET: begin
          if (quiet_reached && absent_i) begin
            phase_d   = PH_REST;
            elapsed_d = '0;
          end else if (!quiet_reached && !absent_i) begin
            phase_d   = PH_ALARM;
            elapsed_d = '0;
          end
        end
        PH_GRACE: begin
          if (grace_reached && absent_i) begin
            phase_d   = PH_REST;
            elapsed_d = '0;
          end else if (!grace_reached && !absent_i) begin
            phase_d   = PH_WORK;
            elapsed_d = '0;
          end
        end
        default: begin
          // resting, and any unknown phase falls back here
          phase_d = PH_REST;
          if (rest_reached && !rest_complete_q) begin
            rest_complete_d = 1'b1;
            chirp           = 1'b1;
          end
          if (!absent_i) begin
            phase_d = PH_WORK;
            if (rest_complete_d) begin
              elapsed_d       = '0;
              rest_complete_d = 1'b0;
            end
          end
        end
      endcase
    end
  end

  // state registers, advanced on each accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= PH_REST;
      started_q       <= 1'b0;
      elapsed_q       <= '0;
      rest_complete_q <= 1'b0;
      alarm_level_q   <= 1'b0;
      blink_waiting_q <= 1'b0;
      blink_elapsed_q <= '0;
    end else if (tick_i) begin
      phase_q         <= phase_d;
      started_q       <= started_d;
      elapsed_q       <= elapsed_d;
      rest_complete_q <= rest_complete_d;
      alarm_level_q   <= alarm_level_d;
      blink_waiting_q <= blink_waiting_d;
      blink_elapsed_q <= blink_elapsed_d;
    end
  end

  assign result_o.phase      = phase_d;
  assign result_o.alarm_out  = alarm_level_d;
  assign result_o.rest_chirp = chirp;

endmodule

// ----- design/wsat_out_reg.sv -----
// result register with handshake, refilled in the cycle it drains
module wsat_out_reg
  import wsat_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         load_i,
  input  wsat_result_t result_i,
  input  logic         out_ready_i,
  output logic         out_valid_o,
  output wsat_result_t result_o,
  output logic         space_o
);

  logic         valid_q, valid_d;
  wsat_result_t result_q;

  // free when empty or being taken this cycle
  assign space_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

// ----- design/work_session_alarm_timer_core.sv -----
// top level of the work session alarm timer
// a result is registered and shown in the cycle after its tick request is accepted
// throughput: one tick per cycle while the result register has space
// the result register frees itself in the cycle its result is taken
// reset: limits return to their defaults, phase to resting and every counter to zero
module work_session_alarm_timer_core
  import wsat_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = CountWidth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  wsat_in_if.sink      in_i,
  wsat_out_if.source   out_o,
  wsat_cfg_if.sink     cfg_i
);

  wsat_cfg_t    cfg;
  wsat_result_t tick_result;
  wsat_result_t out_result;
  logic         space;
  logic         tick_accept;

  // register writes are always taken
  assign cfg_i.ready = 1'b1;

  wsat_cfg_regs u_cfg_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_i.valid),
    .wr_idx_i  (cfg_i.index),
    .wr_data_i (cfg_i.data),
    .cfg_o     (cfg)
  );

  // tick request handshake
  assign in_i.ready  = space;
  assign tick_accept = in_i.valid && space;

  wsat_ctrl #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tick_i   (tick_accept),
    .absent_i (in_i.sensor_high),
    .cfg_i    (cfg),
    .result_o (tick_result)
  );

  wsat_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (tick_accept),
    .result_i    (tick_result),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .result_o    (out_result),
    .space_o     (space)
  );

  assign out_o.phase      = out_result.phase;
  assign out_o.alarm_out  = out_result.alarm_out;
  assign out_o.rest_chirp = out_result.rest_chirp;

endmodule

// ----- test/wsat_checker.sv -----
// checker for the work session alarm timer: follows tick and register requests and compares results
`timescale 1ns / 1ps
module wsat_checker
  import wsat_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  wsat_in_if          tick_i,
  wsat_out_if         result_i,
  wsat_cfg_if         cfg_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  localparam int unsigned ReportLimit = 10;
  localparam logic [CountWidth-1:0] CountMax = '1;

  // own copy of the limits and of the session state
  wsat_cfg_t             limits;
  phase_e                phase_q;
  logic                  started_q;
  logic                  rest_done_q;
  logic                  alarm_q;
  logic                  blink_wait_q;
  logic [CountWidth-1:0] elapsed_q;
  logic [CountWidth-1:0] blink_elapsed_q;

  wsat_result_t results_due[$];
  int unsigned  mismatches = 0;

  // counters stop at their top value
  function automatic logic [CountWidth-1:0] count_up_sat(input logic [CountWidth-1:0] v);
    return (v == CountMax) ? v : v + 1'b1;
  endfunction

  // one tick of the session: updates the state and gives the result it shows
  function automatic wsat_result_t advance_session(input logic absent);
    wsat_result_t res;
    logic         chirp;
    chirp = 1'b0;
    if (!started_q) begin
      // first tick only picks resting or working
      started_q = 1'b1;
      phase_q   = absent ? PH_REST : PH_WORK;
      elapsed_q = '0;
    end else begin
      elapsed_q       = count_up_sat(elapsed_q);
      blink_elapsed_q = count_up_sat(blink_elapsed_q);
      case (phase_q)
        PH_WORK: begin
          // reaching the limit and leaving for grace may both happen in one tick
          if (elapsed_q >= limits.work_ticks) begin
            phase_q   = PH_ALARM;
            elapsed_q = '0;
          end
          if (elapsed_q < limits.work_ticks && absent) begin
            phase_q   = PH_GRACE;
            elapsed_q = '0;
          end
        end
        PH_ALARM: begin
          // blink toggles then waits out its interval
          if (!blink_wait_q) begin
            alarm_q         = ~alarm_q;
            blink_elapsed_q = '0;
            blink_wait_q    = 1'b1;
          end else if (blink_elapsed_q >= limits.blink_ticks) begin
            blink_wait_q = 1'b0;
          end
          if (absent) begin
            phase_q   = PH_QUIET;
            elapsed_q = '0;
            alarm_q   = 1'b0;
          end
        end
        PH_QUIET: begin
          if (elapsed_q >= limits.alarm_quiet_ticks && absent) begin
            elapsed_q = '0;
            phase_q   = PH_REST;
          end
          if (elapsed_q < limits.alarm_quiet_ticks && !absent) begin
            elapsed_q = '0;
            phase_q   = PH_ALARM;
          end
        end
        PH_GRACE: begin
          if (elapsed_q >= limits.break_grace_ticks && absent) begin
            elapsed_q = '0;
            phase_q   = PH_REST;
          end
          if (elapsed_q < limits.break_grace_ticks && !absent) begin
            elapsed_q = '0;
            phase_q   = PH_WORK;
          end
        end
        default: begin
          // resting, and any unknown phase falls back here
          phase_q = PH_REST;
          if (elapsed_q >= limits.rest_ticks && !rest_done_q) begin
            rest_done_q = 1'b1;
            chirp       = 1'b1;
          end
          if (!absent) begin
            phase_q = PH_WORK;
            if (rest_done_q) begin
              elapsed_q   = '0;
              rest_done_q = 1'b0;
            end
          end
        end
      endcase
    end
    res.phase      = phase_q;
    res.alarm_out  = alarm_q;
    res.rest_chirp = chirp;
    return res;
  endfunction

  // follow every request on the three channels
  always @(posedge clk_i or negedge rst_ni) begin : follow
    wsat_result_t want;
    if (!rst_ni) begin
      limits.rest_ticks        = RestTicksDef;
      limits.work_ticks        = WorkTicksDef;
      limits.alarm_quiet_ticks = AlarmQuietTicksDef;
      limits.break_grace_ticks = BreakGraceTicksDef;
      limits.blink_ticks       = BlinkTicksDef;
      phase_q                  = PH_REST;
      started_q                = 1'b0;
      rest_done_q              = 1'b0;
      alarm_q                  = 1'b0;
      blink_wait_q             = 1'b0;
      elapsed_q                = '0;
      blink_elapsed_q          = '0;
      results_due.delete();
      pending_o    <= 0;
      fail_count_o <= mismatches;
    end else begin
      // a result is checked against the oldest tick still waiting
      if (result_i.valid && result_i.ready) begin
        if (results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= ReportLimit)
            $display("%0t: result phase=%0d alarm=%0b chirp=%0b with no tick waiting",
                     $time, result_i.phase, result_i.alarm_out, result_i.rest_chirp);
        end else begin
          want = results_due.pop_front();
          if (result_i.phase !== want.phase || result_i.alarm_out !== want.alarm_out ||
              result_i.rest_chirp !== want.rest_chirp) begin
            mismatches++;
            if (mismatches <= ReportLimit)
              $display("%0t: result mismatch: expected phase=%0d alarm=%0b chirp=%0b, got phase=%0d alarm=%0b chirp=%0b",
                       $time, want.phase, want.alarm_out, want.rest_chirp,
                       result_i.phase, result_i.alarm_out, result_i.rest_chirp);
          end
        end
      end
      // register writes, spare indexes change nothing
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CFG_REST_TICKS:  limits.rest_ticks        = cfg_i.data;
          CFG_WORK_TICKS:  limits.work_ticks        = cfg_i.data;
          CFG_QUIET_TICKS: limits.alarm_quiet_ticks = cfg_i.data;
          CFG_GRACE_TICKS: limits.break_grace_ticks = cfg_i.data;
          CFG_BLINK_TICKS: limits.blink_ticks       = cfg_i.data;
          default: ;
        endcase
      end
      // each accepted tick owes exactly one result
      if (tick_i.valid && tick_i.ready)
        results_due.push_back(advance_session(tick_i.sensor_high));
      pending_o    <= results_due.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

// ----- test/testbench.sv -----
// testbench top for the work session alarm timer: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module testbench;
  import wsat_pkg::*;

  localparam int unsigned ClkPeriod    = 8;
  localparam int unsigned ResetCycles  = 11;
  localparam int unsigned PhaseCount   = 12;
  localparam int unsigned PhaseTicks   = 160;
  localparam int unsigned HoldCycles   = 60;
  localparam int unsigned DrainCycles  = 4;
  localparam int unsigned LimitCycles  = 250000;
  localparam int unsigned IdleLowPct   = 8;
  localparam int unsigned IdleHighPct  = 65;
  localparam logic [31:0] WorkTicksMin = 32'd1;
  localparam logic [2:0]  CfgIdxSpareLo = 3'd5;
  localparam logic [2:0]  CfgIdxSpareHi = 3'd7;
  // directed ticks, first one sent first, 1 = absent
  localparam logic [24:0] DirectedTicks = 25'b1_111_0_000_00_1_0_1111_0_1_0_1111_00;

  // how the limits of one phase are chosen
  typedef enum int unsigned {LIM_SMALL, LIM_FLOOR, LIM_MAX, LIM_MIXED} limit_kind_e;

  logic        clk_i;
  logic        rst_ni;
  int unsigned mismatches;
  int unsigned results_pending;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned holds_asked;

  wsat_in_if  tick_if ();
  wsat_out_if result_if ();
  wsat_cfg_if cfg_if ();

  work_session_alarm_timer_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (tick_if),
    .out_o  (result_if),
    .cfg_i  (cfg_if)
  );

  wsat_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tick_i       (tick_if),
    .result_i     (result_if),
    .cfg_i        (cfg_if),
    .fail_count_o (mismatches),
    .pending_o    (results_pending)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #(LimitCycles * ClkPeriod);
    $display("TEST FAILED");
    $finish;
  end

  // result side: random stalls plus long hold-offs on demand
  initial begin : result_taker
    int unsigned hold_left;
    int unsigned holds_done;
    hold_left        = 0;
    holds_done       = 0;
    result_if.ready  = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        hold_left--;
        result_if.ready <= 1'b0;
      end else if (holds_done != holds_asked) begin
        holds_done = holds_asked;
        hold_left  = HoldCycles - 1;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= ($urandom_range(99, 0) >= rx_idle_pct);
      end
    end
  end

  // offer one tick request, keeping valid high for a following one
  task automatic send_tick(input logic absent);
    while ($urandom_range(99, 0) < tx_idle_pct) begin
      tick_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    tick_if.valid       <= 1'b1;
    tick_if.sensor_high <= absent;
    do @(posedge clk_i); while (!tick_if.ready);
  endtask

  // stop offering and wait until every result is in
  task automatic wait_idle();
    tick_if.valid <= 1'b0;
    do @(posedge clk_i); while (results_pending != 0);
  endtask

  task automatic write_limit(input logic [2:0] index, input logic [31:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= index;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
  endtask

  function automatic logic [31:0] pick_limit(input limit_kind_e kind, input logic [31:0] lowest);
    logic [31:0] val;
    case (kind)
      LIM_SMALL: val = $urandom_range(8, lowest);
      LIM_FLOOR: val = lowest;
      LIM_MAX:   val = '1;
      default: begin
        case ($urandom_range(4, 0))
          0:       val = lowest;
          1:       val = lowest + 1;
          2:       val = '1;
          3:       val = $urandom;
          default: val = $urandom_range(12, lowest);
        endcase
      end
    endcase
    return val;
  endfunction

  // length of a stretch of one sensor level: mostly short, some noise, a few long
  function automatic int unsigned pick_run();
    int unsigned roll;
    roll = $urandom_range(99, 0);
    if (roll < 20) return $urandom_range(2, 1);
    if (roll < 90) return $urandom_range(12, 1);
    return $urandom_range(40, 20);
  endfunction

  // stimulus and verdict
  initial begin : stimulus
    int unsigned sent;
    int unsigned run_left;
    logic        level;
    limit_kind_e kind;
    rst_ni              = 1'b0;
    tick_if.valid       = 1'b0;
    tick_if.sensor_high = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.index        = CFG_REST_TICKS;
    cfg_if.data         = '0;
    tx_idle_pct         = IdleLowPct;
    rx_idle_pct         = IdleHighPct;
    holds_asked         = 0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: a few ticks on the reset limits, then short limits through every phase
    for (int i = 24; i >= 0; i--) begin
      send_tick((i == 24) ? logic'($urandom_range(1, 0)) : DirectedTicks[i]);
      if (i == 22) begin
        wait_idle();
        write_limit(CFG_REST_TICKS, 32'd2);
        write_limit(CFG_WORK_TICKS, 32'd3);
        write_limit(CFG_QUIET_TICKS, 32'd2);
        write_limit(CFG_GRACE_TICKS, 32'd2);
        write_limit(CFG_BLINK_TICKS, 32'd1);
        cfg_if.valid <= 1'b0;
      end
    end

    // random phases, each with its own limits and idling
    level = 1'($urandom_range(1, 0));
    for (int p = 0; p < PhaseCount; p++) begin
      kind = limit_kind_e'(p % 4);
      wait_idle();
      case (p / 4)
        0: begin
          tx_idle_pct <= IdleLowPct;
          rx_idle_pct <= IdleHighPct;
        end
        1: begin
          tx_idle_pct <= IdleHighPct;
          rx_idle_pct <= IdleLowPct;
        end
        default: begin
          tx_idle_pct <= 0;
          rx_idle_pct <= 0;
        end
      endcase
      write_limit(CFG_REST_TICKS, pick_limit(kind, 32'd0));
      write_limit(CFG_WORK_TICKS, pick_limit(kind, WorkTicksMin));
      write_limit(CFG_QUIET_TICKS, pick_limit(kind, 32'd0));
      write_limit(CFG_GRACE_TICKS, pick_limit(kind, 32'd0));
      write_limit(CFG_BLINK_TICKS, pick_limit(kind, 32'd0));
      write_limit(3'($urandom_range(CfgIdxSpareHi, CfgIdxSpareLo)), $urandom);
      cfg_if.valid <= 1'b0;
      sent     = 0;
      run_left = 0;
      while (sent < PhaseTicks) begin
        if (run_left == 0) begin
          level    = ~level;
          run_left = pick_run();
        end
        // long hold-off on the result side while ticks keep coming
        if (p % 4 == 1 && sent == PhaseTicks / 2)
          holds_asked <= holds_asked + 1;
        send_tick(level);
        sent++;
        run_left--;
      end
    end

    wait_idle();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
